// File: hdl/fcfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfla_pkg
// Shared widths, reset values and codes of the fixed chunk free list allocator.
// ----------------------------------------------------------------------------
package fcfla_pkg;

	localparam int ADDR_W   = 48;
	localparam int CS_W     = 17;
	localparam int CC_W     = 11;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	localparam int FC_W     = 11;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	localparam int MAX_CHUNKS_DEF = 1024;

	localparam logic [ADDR_W-1:0] RESET_BASE       = '0;
	localparam logic [CS_W-1:0]   RESET_CHUNK_SIZE = CS_W'(64);
	localparam logic [CC_W-1:0]   RESET_COUNT      = CC_W'(1024);

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_FREE    = 2'd1,
		KIND_REBUILD = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_BAD_ADDR  = 3'd3,
		ST_IGNORED   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_BASE_ADDRESS = 2'd0,
		REG_CHUNK_SIZE   = 2'd1,
		REG_CHUNK_COUNT  = 2'd2
	} reg_idx_t;

endpackage

// File: hdl/fixed_chunk_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator
// Pool of equal chunks with a LIFO free list kept as next-chunk links in RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | beat
//  ---------+----------------------------+-----------------------------------
//  request  | in_valid / in_stall        | kind, request_size, address
//  result   | out_valid / out_stall      | status, chunk_address, free_count
//  config   | psel penable pwrite pready | paddr, pwdata, prdata (64 bit)
//
// One request at a time through a single 48-bit add/subtract unit.
// Allocate: shift-add of index times chunk size.
// Free: offset, then restoring division by chunk size.
// Rebuild: one link written per cycle.
// After reset a link fill runs with in_stall high.
// A finished result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module fixed_chunk_free_list_allocator #(
	parameter int MAX_CHUNKS = fcfla_pkg::MAX_CHUNKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fcfla_pkg::KIND_W-1:0]        kind,
	input  logic [fcfla_pkg::CS_W-1:0]          request_size,
	input  logic [fcfla_pkg::ADDR_W-1:0]        address,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fcfla_pkg::STATUS_W-1:0]      status,
	output logic [fcfla_pkg::ADDR_W-1:0]        chunk_address,
	output logic [fcfla_pkg::FC_W-1:0]          free_count,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fcfla_pkg::PADDR_W-1:0]       paddr,
	input  logic [fcfla_pkg::PDATA_W-1:0]       pwdata,
	output logic [fcfla_pkg::PDATA_W-1:0]       prdata,
	output logic                                pready
);

	localparam int ADDR_W = fcfla_pkg::ADDR_W;
	localparam int CS_W   = fcfla_pkg::CS_W;
	localparam int CC_W   = fcfla_pkg::CC_W;
	localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
	localparam int DW     = CS_W + IDX_W;
	localparam int KW     = $clog2(IDX_W + 1);
	localparam int RESET_USED = (int'(fcfla_pkg::RESET_COUNT) > MAX_CHUNKS) ?
		MAX_CHUNKS : int'(fcfla_pkg::RESET_COUNT);

	typedef enum logic [7:0] {
		S_INIT = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_OFFS = 8'b0000_0100,
		S_CHK  = 8'b0000_1000,
		S_DIV  = 8'b0001_0000,
		S_MUL  = 8'b0010_0000,
		S_FCHK = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t                     state_q;
	logic [ADDR_W-1:0]          base_q;
	logic [CS_W-1:0]            cs_q;
	logic [CC_W-1:0]            cc_q;
	logic [IDX_W-1:0]           head_q;
	logic [CNT_W-1:0]           total_q;
	logic [CNT_W-1:0]           nb_q;
	logic [IDX_W-1:0]           iw_q;
	logic                       rebuild_q;
	fcfla_pkg::kind_t           kind_q;
	fcfla_pkg::status_t         res_status_q;
	logic [ADDR_W-1:0]          r_q;
	logic [DW-1:0]              d_q;
	logic [IDX_W-1:0]           q_q;
	logic [KW-1:0]              kcnt_q;
	logic                       out_valid_q;
	logic [fcfla_pkg::STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]          chunk_address_q;
	logic [fcfla_pkg::FC_W-1:0] free_count_q;

	logic [CNT_W-1:0]  n_used;
	logic [ADDR_W-1:0] op_b;
	logic              do_sub;
	logic [ADDR_W:0]   sum_w;
	logic [ADDR_W-1:0] alu_sum;
	logic              alu_ge;
	logic              out_free;
	logic              cfg_we;
	logic [1:0]        cfg_idx;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [IDX_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]  ram_rdata;
	logic [CNT_W-1:0]  iw_next;
	logic              push_ok;

	// chunk_count above the built capacity counts as the capacity
	assign n_used = (32'(cc_q) > 32'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : CNT_W'(cc_q);

	// shared add/subtract unit: carry out of a subtract means r >= operand
	assign op_b    = (state_q == S_OFFS) ? base_q : ADDR_W'(d_q);
	assign do_sub  = (state_q != S_MUL);
	assign sum_w   = {1'b0, r_q} + {1'b0, (do_sub ? ~op_b : op_b)} + (ADDR_W+1)'(do_sub);
	assign alu_sum = sum_w[ADDR_W-1:0];
	assign alu_ge  = sum_w[ADDR_W];

	assign out_free = !out_valid_q || !out_stall;
	assign iw_next  = CNT_W'(iw_q) + CNT_W'(1);
	assign push_ok  = (r_q == '0) && (CNT_W'(q_q) < n_used);

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign chunk_address = chunk_address_q;
	assign free_count    = free_count_q;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[fcfla_pkg::PADDR_W-1:3];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (fcfla_pkg::reg_idx_t'(cfg_idx))
			fcfla_pkg::REG_BASE_ADDRESS: prdata = fcfla_pkg::PDATA_W'(base_q);
			fcfla_pkg::REG_CHUNK_SIZE:   prdata = fcfla_pkg::PDATA_W'(cs_q);
			fcfla_pkg::REG_CHUNK_COUNT:  prdata = fcfla_pkg::PDATA_W'(cc_q);
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= fcfla_pkg::RESET_BASE;
			cs_q   <= fcfla_pkg::RESET_CHUNK_SIZE;
			cc_q   <= fcfla_pkg::RESET_COUNT;
		end else if (cfg_we) begin
			unique case (fcfla_pkg::reg_idx_t'(cfg_idx))
				fcfla_pkg::REG_BASE_ADDRESS: base_q <= pwdata[ADDR_W-1:0];
				fcfla_pkg::REG_CHUNK_SIZE:   cs_q   <= pwdata[CS_W-1:0];
				fcfla_pkg::REG_CHUNK_COUNT:  cc_q   <= pwdata[CC_W-1:0];
				default: ;
			endcase
		end
	end

	// link RAM writes: fill pass or push of a freed chunk
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = iw_q;
		ram_wdata = (iw_next < nb_q) ? IDX_W'(iw_next) : '0;
		if (state_q == S_INIT) begin
			ram_we = 1'b1;
		end else if (state_q == S_FCHK) begin
			ram_we    = push_ok;
			ram_waddr = q_q;
			ram_wdata = head_q;
		end
	end

	fcfla_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_CHUNKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			head_q       <= '0;
			total_q      <= CNT_W'(RESET_USED);
			nb_q         <= CNT_W'(RESET_USED);
			iw_q         <= '0;
			rebuild_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			kind_q       <= fcfla_pkg::KIND_ALLOC;
			res_status_q <= fcfla_pkg::ST_OK;
			r_q          <= '0;
			d_q          <= '0;
			q_q          <= '0;
			kcnt_q       <= '0;
		end else begin
			// drop the beat once taken, unless a new one is loaded this cycle
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					iw_q <= iw_q + IDX_W'(1);
					if (iw_q == IDX_W'(MAX_CHUNKS - 1)) begin
						head_q    <= '0;
						total_q   <= nb_q;
						rebuild_q <= 1'b0;
						state_q   <= rebuild_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= fcfla_pkg::kind_t'(kind);
						unique case (fcfla_pkg::kind_t'(kind))
							fcfla_pkg::KIND_ALLOC: begin
								if (request_size > cs_q) begin
									res_status_q <= fcfla_pkg::ST_TOO_LARGE;
									state_q      <= S_DONE;
								end else if (total_q == '0) begin
									res_status_q <= fcfla_pkg::ST_EMPTY;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= fcfla_pkg::ST_OK;
									r_q          <= base_q;
									d_q          <= {cs_q, IDX_W'(0)} >> 1;
									q_q          <= head_q;
									kcnt_q       <= KW'(IDX_W - 1);
									state_q      <= S_MUL;
								end
							end
							fcfla_pkg::KIND_FREE: begin
								if (address == '0) begin
									res_status_q <= fcfla_pkg::ST_IGNORED;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= fcfla_pkg::ST_OK;
									r_q          <= address;
									state_q      <= S_OFFS;
								end
							end
							fcfla_pkg::KIND_REBUILD: begin
								res_status_q <= fcfla_pkg::ST_OK;
								nb_q         <= n_used;
								iw_q         <= '0;
								rebuild_q    <= 1'b1;
								state_q      <= S_INIT;
							end
							default: begin
								res_status_q <= fcfla_pkg::ST_IGNORED;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_OFFS: begin
					r_q     <= alu_sum;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (cs_q == '0) begin
						// zero stride: only offset zero maps to chunk 0
						q_q <= '0;
						if (r_q == '0) begin
							state_q <= S_FCHK;
						end else begin
							res_status_q <= fcfla_pkg::ST_BAD_ADDR;
							state_q      <= S_DONE;
						end
					end else begin
						d_q     <= {cs_q, IDX_W'(0)};
						q_q     <= '0;
						kcnt_q  <= KW'(IDX_W);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					d_q <= d_q >> 1;
					if (kcnt_q == KW'(IDX_W)) begin
						// quotient would not fit the index: out of the pool
						if (alu_ge) begin
							res_status_q <= fcfla_pkg::ST_BAD_ADDR;
							state_q      <= S_DONE;
						end
						kcnt_q <= kcnt_q - KW'(1);
					end else begin
						if (alu_ge) begin
							r_q <= alu_sum;
						end
						q_q <= (q_q << 1) | IDX_W'(alu_ge);
						if (kcnt_q == '0) begin
							state_q <= S_FCHK;
						end else begin
							kcnt_q <= kcnt_q - KW'(1);
						end
					end
				end
				S_MUL: begin
					if (q_q[IDX_W-1]) begin
						r_q <= alu_sum;
					end
					q_q <= q_q << 1;
					d_q <= d_q >> 1;
					if (kcnt_q == '0) begin
						head_q  <= ram_rdata;
						total_q <= total_q - CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						kcnt_q <= kcnt_q - KW'(1);
					end
				end
				S_FCHK: begin
					if (push_ok) begin
						head_q <= q_q;
						if (total_q < CNT_W'(MAX_CHUNKS)) begin
							total_q <= total_q + CNT_W'(1);
						end
					end else begin
						res_status_q <= fcfla_pkg::ST_BAD_ADDR;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status_q        <= res_status_q;
			chunk_address_q <= ((res_status_q == fcfla_pkg::ST_OK) &&
				(kind_q == fcfla_pkg::KIND_ALLOC)) ? r_q : '0;
			free_count_q    <= fcfla_pkg::FC_W'(total_q);
		end
	end

endmodule

// File: hdl/fcfla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfla_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed chunk free list allocator. A scoreboard
// keeps its own copy of the free list and registers, predicts one result per
// accepted request and checks the result beats in order. A short directed
// run covers the edge cases of the pool. Random runs follow under several
// pool settings, with idle cycles on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import fcfla_pkg::*;

	localparam int POOL_DEPTH = MAX_CHUNKS_DEF;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
	localparam int IDLE_PCT    = 9;
	localparam int HOLD_AT     = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_FROM  = 700;
	localparam int QUIET_TO    = 1000;
	localparam int MAX_LOGGED  = 100;
	localparam longint LIMIT_NS = 64'd50_000_000;

	typedef struct {
		status_t           status;
		logic [ADDR_W-1:0] chunk_address;
		logic [FC_W-1:0]   free_count;
	} alloc_result_t;

	typedef struct {
		logic [PDATA_W-1:0] base;
		logic [PDATA_W-1:0] size;
		logic [PDATA_W-1:0] count;
		int                 items;
	} pool_setting_t;

	class pool_scoreboard;
		logic [ADDR_W-1:0] base_address;
		logic [CS_W-1:0]   chunk_size;
		logic [CC_W-1:0]   chunk_count;
		int unsigned       next_link [POOL_DEPTH];
		int unsigned       free_head;
		int unsigned       free_total;
		alloc_result_t     awaited [$];
		logic [ADDR_W-1:0] live_chunks [$];
		int                errors;
		int                results_checked;
		int                requests_noted;
		int                kind_seen [4];

		function new();
			base_address = RESET_BASE;
			chunk_size = RESET_CHUNK_SIZE;
			chunk_count = RESET_COUNT;
			errors = 0;
			results_checked = 0;
			requests_noted = 0;
			foreach (kind_seen[i])
				kind_seen[i] = 0;
			relink(pool_chunks());
		endfunction

		function int unsigned pool_chunks();
			return (chunk_count > CC_W'(POOL_DEPTH)) ? POOL_DEPTH : 32'(chunk_count);
		endfunction

		function void relink(int unsigned n);
			for (int unsigned i = 0; i < POOL_DEPTH; i++)
				next_link[i] = (i + 1 < n) ? i + 1 : 0;
			free_head = 0;
			free_total = n;
			live_chunks.delete();
		endfunction

		function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
			case (idx)
			REG_BASE_ADDRESS: base_address = value[ADDR_W-1:0];
			REG_CHUNK_SIZE:   chunk_size = value[CS_W-1:0];
			REG_CHUNK_COUNT:  chunk_count = value[CC_W-1:0];
			default: ;
			endcase
			// old addresses mean nothing under new registers
			live_chunks.delete();
		endfunction

		function logic [PDATA_W-1:0] reg_value(reg_idx_t idx);
			case (idx)
			REG_BASE_ADDRESS: return PDATA_W'(base_address);
			REG_CHUNK_SIZE:   return PDATA_W'(chunk_size);
			REG_CHUNK_COUNT:  return PDATA_W'(chunk_count);
			default:          return '0;
			endcase
		endfunction

		function void note_request(logic [KIND_W-1:0] k, logic [CS_W-1:0] rs,
				logic [ADDR_W-1:0] ad);
			alloc_result_t     r;
			int unsigned       n;
			int unsigned       slot;
			logic [ADDR_W-1:0] offset;
			logic [63:0]       span;
			logic [63:0]       stride;
			bit                ok;
			n = pool_chunks();
			stride = 64'(chunk_size);
			r.status = ST_OK;
			r.chunk_address = '0;
			requests_noted++;
			kind_seen[k]++;
			case (k)
			KIND_ALLOC: begin
				if (rs > chunk_size)
					r.status = ST_TOO_LARGE;
				else if (free_total == 0)
					r.status = ST_EMPTY;
				else begin
					slot = (free_head >= POOL_DEPTH) ? 0 : free_head;
					free_head = next_link[slot];
					free_total--;
					span = 64'(slot) * stride;
					r.chunk_address = base_address + span[ADDR_W-1:0];
					live_chunks.push_back(r.chunk_address);
				end
			end
			KIND_FREE: begin
				if (ad == '0)
					r.status = ST_IGNORED;
				else begin
					offset = ad - base_address;
					slot = 0;
					if (chunk_size == '0)
						ok = (offset == '0) && (n > 0);
					else begin
						span = 64'(n) * stride;
						ok = (64'(offset) < span) && (64'(offset) % stride == 64'd0);
						if (ok)
							slot = 32'(64'(offset) / stride);
					end
					if (!ok || slot >= POOL_DEPTH)
						r.status = ST_BAD_ADDR;
					else begin
						next_link[slot] = free_head;
						free_head = slot;
						// count saturates on a double free
						if (free_total < POOL_DEPTH)
							free_total++;
					end
				end
			end
			KIND_REBUILD: relink(n);
			default: r.status = ST_IGNORED;
			endcase
			r.free_count = FC_W'(free_total);
			awaited.push_back(r);
		endfunction

		task report(string what);
			errors++;
			if (errors <= MAX_LOGGED)
				$display("%0t ns mismatch: %s", $time, what);
		endtask

		task check_result(logic [STATUS_W-1:0] st, logic [ADDR_W-1:0] ca,
				logic [FC_W-1:0] fc);
			alloc_result_t want;
			results_checked++;
			if (awaited.size() == 0) begin
				report($sformatf("result beat with nothing awaited (status %0d)", st));
				return;
			end
			want = awaited.pop_front();
			if (st !== want.status)
				report($sformatf("result %0d status %0d, want %0d",
					results_checked, st, want.status));
			if (ca !== want.chunk_address)
				report($sformatf("result %0d chunk_address %h, want %h",
					results_checked, ca, want.chunk_address));
			if (fc !== want.free_count)
				report($sformatf("result %0d free_count %0d, want %0d",
					results_checked, fc, want.free_count));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [KIND_W-1:0]   kind = '0;
	logic [CS_W-1:0]     request_size = '0;
	logic [ADDR_W-1:0]   address = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   chunk_address;
	logic [FC_W-1:0]     free_count;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	pool_scoreboard sb = new();
	int settings_used = 0;

	fixed_chunk_free_list_allocator uut (.*);

	initial begin : clock_gen
		forever #4 clk = ~clk;
	end

	function automatic logic [ADDR_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ADDR_W-1:0];
	endfunction

	function automatic logic [PADDR_W-1:0] reg_offset(reg_idx_t idx);
		return PADDR_W'({idx, 3'b000});
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= reg_offset(idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic readback_reg(input reg_idx_t idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= reg_offset(idx);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== sb.reg_value(idx))
			sb.report($sformatf("register %0d reads %h, want %h",
				idx, prdata, sb.reg_value(idx)));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [PDATA_W-1:0] base,
			input logic [PDATA_W-1:0] size, input logic [PDATA_W-1:0] count);
		write_reg(REG_BASE_ADDRESS, base);
		write_reg(REG_CHUNK_SIZE, size);
		write_reg(REG_CHUNK_COUNT, count);
		readback_reg(REG_BASE_ADDRESS);
		readback_reg(REG_CHUNK_SIZE);
		readback_reg(REG_CHUNK_COUNT);
		settings_used++;
	endtask

	// valid stays high between back-to-back beats; drop it only for a gap
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [CS_W-1:0] rs,
			input logic [ADDR_W-1:0] ad);
		bit quiet;
		quiet = sb.requests_noted >= QUIET_FROM && sb.requests_noted < QUIET_TO;
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		request_size <= rs;
		address <= ad;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_request(k, rs, ad);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// mostly allocate and give back live chunks; the rest is noise
	function automatic void pick_random(output logic [KIND_W-1:0] k,
			output logic [CS_W-1:0] rs, output logic [ADDR_W-1:0] ad);
		int unsigned       roll;
		int unsigned       n;
		int unsigned       pick;
		int unsigned       cs;
		logic [ADDR_W-1:0] stride;
		roll = $urandom_range(99);
		n = sb.pool_chunks();
		cs = 32'(sb.chunk_size);
		stride = ADDR_W'(sb.chunk_size);
		k = KIND_ALLOC;
		rs = CS_W'($urandom_range(0, cs));
		ad = rand48();
		if (roll < 40) begin
		end else if (roll < 45)
			rs = CS_W'($urandom);
		else if (roll < 84) begin
			if (sb.live_chunks.size() != 0) begin
				pick = $urandom_range(sb.live_chunks.size() - 1);
				k = KIND_FREE;
				rs = CS_W'($urandom);
				ad = sb.live_chunks[pick];
				sb.live_chunks.delete(pick);
			end
		end else if (roll < 94) begin
			k = KIND_FREE;
			rs = CS_W'($urandom);
			pick = $urandom_range((n > 0) ? n - 1 : 0);
			ad = sb.base_address + ADDR_W'(pick) * stride;
			if (roll >= 87 && roll < 90)
				ad = ad + ADDR_W'($urandom_range(1, (cs > 1) ? cs - 1 : 15));
			else if (roll >= 90 && roll < 92)
				ad = sb.base_address + ADDR_W'(n + $urandom_range(0, 3)) * stride;
			else if (roll >= 92)
				ad = rand48();
		end else if (roll < 96) begin
			k = KIND_FREE;
			rs = CS_W'($urandom);
			ad = '0;
		end else if (roll < 97) begin
			k = KIND_UNKNOWN;
			rs = CS_W'($urandom);
		end else if (roll < 98) begin
			k = KIND_REBUILD;
			rs = CS_W'($urandom);
		end else if (cs < 32'h1FFFF)
			rs = CS_W'($urandom_range(cs + 1, 32'h1FFFF));
	endfunction

	initial begin : stimulus
		pool_setting_t     plan [8];
		logic [KIND_W-1:0] k;
		logic [CS_W-1:0]   rs;
		logic [ADDR_W-1:0] ad;
		plan[0] = '{64'h1000, 64'd16, 64'd8, 250};
		plan[1] = '{64'(rand48()), 64'd65536, 64'd1024, 250};
		plan[2] = '{64'(rand48()), 64'($urandom_range(16, 65536)),
			64'($urandom_range(1, 1024)), 350};
		plan[3] = '{64'h0000_FFFF_FFFF_0000, 64'd48, 64'd2047, 300};
		plan[4] = '{64'(rand48()), 64'd0, 64'd3, 100};
		plan[5] = '{64'h40, 64'd64, 64'd0, 60};
		plan[6] = '{64'd0, 64'($urandom_range(16, 65536)), 64'd1024, 300};
		plan[7] = '{64'(rand48()), 64'd100, 64'd1, 200};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset pool: chunk 0 lies at address 0, every chunk free
		send_item(KIND_ALLOC, 17'd0, rand48());
		send_item(KIND_ALLOC, 17'd64, rand48());
		send_item(KIND_ALLOC, 17'd65, rand48());
		send_item(KIND_ALLOC, 17'h1FFFF, rand48());
		send_item(KIND_FREE, CS_W'($urandom), 48'h0);
		send_item(KIND_FREE, CS_W'($urandom), 48'h40);
		send_item(KIND_FREE, CS_W'($urandom), 48'h41);
		send_item(KIND_FREE, CS_W'($urandom), 48'h1_0000);
		send_item(KIND_FREE, CS_W'($urandom), 48'hFFFF_FFFF_FFFF);
		send_item(KIND_UNKNOWN, CS_W'($urandom), rand48());
		send_item(KIND_FREE, CS_W'($urandom), 48'h40);
		send_item(KIND_REBUILD, CS_W'($urandom), rand48());
		send_item(KIND_FREE, CS_W'($urandom), 48'h80);
		drain();

		// four chunks wrapping past the top of the address space
		apply_setting(64'h0000_FFFF_FFFF_FFC0, 64'd64, 64'd4);
		send_item(KIND_REBUILD, CS_W'($urandom), rand48());
		repeat (5)
			send_item(KIND_ALLOC, CS_W'($urandom_range(0, 64)), rand48());
		send_item(KIND_FREE, CS_W'($urandom), 48'h0);
		send_item(KIND_FREE, CS_W'($urandom), 48'hFFFF_FFFF_FFC0);
		send_item(KIND_FREE, CS_W'($urandom), 48'h80);
		send_item(KIND_FREE, CS_W'($urandom), 48'hC0);

		foreach (plan[p]) begin
			drain();
			apply_setting(plan[p].base, plan[p].size, plan[p].count);
			send_item(KIND_REBUILD, CS_W'($urandom), rand48());
			repeat (plan[p].items) begin
				pick_random(k, rs, ad);
				send_item(k, rs, ad);
			end
		end
		drain();
		repeat (POOL_DEPTH + 64) @(posedge clk);

		$display("covered %0d requests (%0d allocate, %0d free, %0d rebuild, %0d unknown)",
			sb.requests_noted, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2],
			sb.kind_seen[3]);
		$display("over %0d pool settings; %0d results compared, %0d mismatches",
			settings_used, sb.results_checked, sb.errors);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : result_sink
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0)
				sb.check_result(status, chunk_address, free_count);
			// hold off long enough for the request side to back up
			if (!held && sb.results_checked >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (sb.results_checked >= QUIET_FROM && sb.results_checked < QUIET_TO)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
hdl/fcfla_pkg.sv
hdl/fcfla_ram.sv
hdl/fixed_chunk_free_list_allocator.sv
sim/tb_top.sv
